// ===== rtl/sync_cursor_table_parser_assert.svh =====
// ----------------------------------------------------------------------------
// sync_cursor_table_parser_assert.svh
// Assertion macros used by the cursor table parser RTL.
// ----------------------------------------------------------------------------
`ifndef SYNC_CURSOR_TABLE_PARSER_ASSERT_SVH
`define SYNC_CURSOR_TABLE_PARSER_ASSERT_SVH

// Condition must never hold outside reset.
`define SCTP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SCTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SCTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sctp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctp_pkg
// Constants and types of the cursor table parser.
// ----------------------------------------------------------------------------
package sctp_pkg;

  localparam int MAX_ENTRIES   = 16;
  localparam int HEADER_BYTES  = 4;
  localparam int ENTRY_BYTES   = 14;
  localparam int TABLE_VERSION = 1;
  localparam int POS_LIMIT     = HEADER_BYTES + ENTRY_BYTES * MAX_ENTRIES + 1;

  localparam int POS_W   = $clog2(POS_LIMIT + 1);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int OFF_W   = $clog2(ENTRY_BYTES);
  localparam int KEY_W   = 16;
  localparam int REV_W   = 32;
  localparam int TOTAL_W = 5;

  // byte offsets of the entry fields
  localparam int OFF_ACKED   = 2;
  localparam int OFF_APPLIED = 6;
  localparam int OFF_WAITING = 10;

  typedef enum logic {
    KIND_ENTRY  = 1'b0,
    KIND_STATUS = 1'b1
  } rec_kind_t;

  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_BAD = 1'b1
  } parse_status_t;

  typedef struct packed {
    rec_kind_t           kind;
    logic [KEY_W-1:0]    key;
    logic [REV_W-1:0]    acked;
    logic [REV_W-1:0]    applied;
    logic [REV_W-1:0]    waiting;
    parse_status_t       status;
    logic [TOTAL_W-1:0]  total;
  } rec_t;

  // control from the parser into the key chain
  typedef struct packed {
    logic             shift;
    logic [KEY_W-1:0] key;
  } key_probe_t;

endpackage

// ===== rtl/sctp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctp_in_if
// Byte channel into the parser: one table byte per word.
// ----------------------------------------------------------------------------
interface sctp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

// ===== rtl/sctp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctp_out_if
// Record channel out of the parser: one entry or status record per word.
// ----------------------------------------------------------------------------
interface sctp_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [15:0] entry_key;
  logic [31:0] acked_revision;
  logic [31:0] applied_revision;
  logic [31:0] waiting_revision;
  logic        parse_status;
  logic [4:0]  entry_total;

  modport source (output valid, record_kind, entry_key, acked_revision,
                  applied_revision, waiting_revision, parse_status, entry_total,
                  input ready);
  modport sink   (input valid, record_kind, entry_key, acked_revision,
                  applied_revision, waiting_revision, parse_status, entry_total,
                  output ready);
endinterface

// ===== rtl/sctp_key_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctp_key_cell
// One stored key: shifts to its neighbor on insert, ORs its match into the chain.
// ----------------------------------------------------------------------------
module sctp_key_cell
  import sctp_pkg::*;
(
  input  logic             clk,
  input  logic             shift,
  input  logic [KEY_W-1:0] key_in,
  input  logic [KEY_W-1:0] probe,
  input  logic             live,
  input  logic             match_in,
  output logic [KEY_W-1:0] key_out,
  output logic             match_out
);

  logic [KEY_W-1:0] key;

  always_ff @(posedge clk) begin
    if (shift) begin
      key <= key_in;
    end
  end

  assign key_out   = key;
  assign match_out = match_in | (live & (key == probe));

endmodule

// ===== rtl/sctp_key_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctp_key_chain
// Row of key cells, newest key in cell 0; flags a repeat of the probe key.
// ----------------------------------------------------------------------------
module sctp_key_chain
  import sctp_pkg::*;
(
  input  logic             clk,
  input  key_probe_t       ctl,
  input  logic [CNT_W-1:0] entries_done,
  output logic             dup
);

  logic [KEY_W-1:0] key_link [MAX_ENTRIES+1];
  logic             match_link [MAX_ENTRIES+1];

  assign key_link[0]   = ctl.key;
  assign match_link[0] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    // cells below the fill level hold keys of this table
    logic live;
    assign live = (CNT_W'(i) < entries_done);

    sctp_key_cell u_cell (
      .clk       (clk),
      .shift     (ctl.shift),
      .key_in    (key_link[i]),
      .probe     (ctl.key),
      .live      (live),
      .match_in  (match_link[i]),
      .key_out   (key_link[i+1]),
      .match_out (match_link[i+1])
    );
  end

  assign dup = match_link[MAX_ENTRIES];

endmodule

// ===== rtl/sync_cursor_table_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_cursor_table_parser
// Streaming cursor table parser with per-entry records and a final status.
// ----------------------------------------------------------------------------
// The block takes one table byte per cycle on byte_in and, when it completes a
// 14-byte entry that is well formed, puts an entry record on rec_out; the byte
// flagged final produces a status record (ok with the entry count, or
// malformed with a zero count) and returns the parser to its start state for
// the next table. Bytes keep flowing as long as rec_out keeps taking words:
// the single output register lets the next byte in while the last record is
// taken. A final byte that also completes an entry yields two words; the
// status word waits in a holding register and byte_in stalls while it is
// held. Duplicate keys are found by a row of MAX_ENTRIES key cells, each
// comparing its stored key against the entry's key in the same cycle; a good
// entry shifts its key into the row. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sync_cursor_table_parser
  import sctp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sctp_in_if.sink     byte_in,
  sctp_out_if.source  rec_out
);

`include "sync_cursor_table_parser_assert.svh"

  // parse state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [CNT_W-1:0] declared_count, declared_count_next;
  logic [CNT_W-1:0] entries_done, entries_done_next;
  logic [OFF_W-1:0] field_off, field_off_next;
  logic             error_seen, error_next;

  // entry being assembled (payload, no reset)
  logic [KEY_W-1:0] assembly_key, assembly_key_next;
  logic [REV_W-1:0] assembly_acked, assembly_acked_next;
  logic [REV_W-1:0] assembly_applied, assembly_applied_next;
  logic [REV_W-1:0] assembly_waiting, assembly_waiting_next;

  // output register and second-word holding register
  logic out_valid;
  rec_t out_rec;
  logic stat_pending;
  rec_t pend_rec;

  logic       accept, out_take;
  logic       emit_entry, table_ok, dup;
  logic [POS_W-1:0] expected;
  logic [OFF_W-1:0] sub;
  rec_t       entry_rec, stat_rec;
  key_probe_t probe;

  assign out_take     = rec_out.valid & rec_out.ready;
  assign byte_in.ready = ~stat_pending & (~out_valid | rec_out.ready);
  assign accept       = byte_in.valid & byte_in.ready;

  assign expected = POS_W'(HEADER_BYTES) + POS_W'(ENTRY_BYTES) * POS_W'(declared_count);

  // key row: probe with the assembled key, insert it on a good entry
  sctp_key_chain u_chain (
    .clk          (clk),
    .ctl          (probe),
    .entries_done (entries_done),
    .dup          (dup)
  );

  always_comb begin
    byte_position_next    = byte_position;
    declared_count_next   = declared_count;
    entries_done_next     = entries_done;
    field_off_next        = field_off;
    error_next            = error_seen;
    assembly_key_next     = assembly_key;
    assembly_acked_next   = assembly_acked;
    assembly_applied_next = assembly_applied;
    assembly_waiting_next = assembly_waiting;
    emit_entry            = 1'b0;
    probe.key             = assembly_key;
    probe.shift           = 1'b0;
    sub                   = '0;

    if (!error_seen) begin
      if (byte_position == POS_W'(0)) begin
        if (byte_in.data_byte != 8'(TABLE_VERSION)) begin
          error_next = 1'b1;
        end
      end else if (byte_position == POS_W'(1)) begin
        if (byte_in.data_byte > 8'(MAX_ENTRIES)) begin
          error_next = 1'b1;
        end else begin
          declared_count_next = byte_in.data_byte[CNT_W-1:0];
        end
      end else if (byte_position < POS_W'(HEADER_BYTES)) begin
        if (byte_in.data_byte != 8'd0) begin
          error_next = 1'b1;
        end
      end else if (byte_position >= expected) begin
        error_next = 1'b1;
      end else begin
        // little-endian byte lanes of each field
        if (field_off < OFF_W'(OFF_ACKED)) begin
          assembly_key_next[{field_off[0], 3'b000} +: 8] = byte_in.data_byte;
        end else if (field_off < OFF_W'(OFF_APPLIED)) begin
          sub = field_off - OFF_W'(OFF_ACKED);
          assembly_acked_next[{sub[1:0], 3'b000} +: 8] = byte_in.data_byte;
        end else if (field_off < OFF_W'(OFF_WAITING)) begin
          sub = field_off - OFF_W'(OFF_APPLIED);
          assembly_applied_next[{sub[1:0], 3'b000} +: 8] = byte_in.data_byte;
        end else begin
          sub = field_off - OFF_W'(OFF_WAITING);
          assembly_waiting_next[{sub[1:0], 3'b000} +: 8] = byte_in.data_byte;
        end

        if (field_off == OFF_W'(ENTRY_BYTES - 1)) begin
          field_off_next = '0;
          // good: nonzero key, pending revision absent or ahead, key not seen
          if (assembly_key_next != '0 &&
              !(assembly_waiting_next != '0 &&
                assembly_waiting_next <= assembly_acked_next) &&
              !dup && entries_done < CNT_W'(MAX_ENTRIES)) begin
            probe.shift       = accept;
            emit_entry        = 1'b1;
            entries_done_next = entries_done + CNT_W'(1);
          end else begin
            error_next = 1'b1;
          end
        end else begin
          field_off_next = field_off + OFF_W'(1);
        end
      end
    end

    if (byte_position < POS_W'(POS_LIMIT)) begin
      byte_position_next = byte_position + POS_W'(1);
    end

    table_ok = ~error_next && (byte_position_next == expected) &&
               (byte_position_next >= POS_W'(HEADER_BYTES));

    entry_rec.kind    = KIND_ENTRY;
    entry_rec.key     = assembly_key_next;
    entry_rec.acked   = assembly_acked_next;
    entry_rec.applied = assembly_applied_next;
    entry_rec.waiting = assembly_waiting_next;
    entry_rec.status  = STATUS_OK;
    entry_rec.total   = '0;

    stat_rec.kind    = KIND_STATUS;
    stat_rec.key     = '0;
    stat_rec.acked   = '0;
    stat_rec.applied = '0;
    stat_rec.waiting = '0;
    stat_rec.status  = table_ok ? STATUS_OK : STATUS_BAD;
    stat_rec.total   = table_ok ? TOTAL_W'(declared_count) : '0;
  end

  // Parse state. Gated shift into the key row comes from probe.shift, which
  // only rises on an accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      declared_count <= '0;
      entries_done   <= '0;
      field_off      <= '0;
      error_seen     <= 1'b0;
    end else if (accept) begin
      if (byte_in.final_byte) begin
        // table done: back to the start state
        byte_position  <= '0;
        declared_count <= '0;
        entries_done   <= '0;
        field_off      <= '0;
        error_seen     <= 1'b0;
      end else begin
        byte_position  <= byte_position_next;
        declared_count <= declared_count_next;
        entries_done   <= entries_done_next;
        field_off      <= field_off_next;
        error_seen     <= error_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      assembly_key     <= assembly_key_next;
      assembly_acked   <= assembly_acked_next;
      assembly_applied <= assembly_applied_next;
      assembly_waiting <= assembly_waiting_next;
    end
  end

  // Output side: entry word first, status word held behind it when both occur.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      stat_pending <= 1'b0;
    end else if (accept && (emit_entry || byte_in.final_byte)) begin
      out_valid    <= 1'b1;
      out_rec      <= emit_entry ? entry_rec : stat_rec;
      stat_pending <= emit_entry & byte_in.final_byte;
      pend_rec     <= stat_rec;
    end else if (out_take) begin
      if (stat_pending) begin
        out_rec      <= pend_rec;
        stat_pending <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rec_out.valid            = out_valid;
  assign rec_out.record_kind      = out_rec.kind;
  assign rec_out.entry_key        = out_rec.key;
  assign rec_out.acked_revision   = out_rec.acked;
  assign rec_out.applied_revision = out_rec.applied;
  assign rec_out.waiting_revision = out_rec.waiting;
  assign rec_out.parse_status     = out_rec.status;
  assign rec_out.entry_total      = out_rec.total;

  // held status word always sits behind a valid output word
  `SCTP_ASSERT_IMP(a_pend_behind_out, stat_pending, out_valid, "status held with empty output")
  // the key row never fills past the declared count
  `SCTP_ASSERT_NEVER(a_done_le_count, entries_done > declared_count, "entries beyond count")
  // a final byte returns the parser to its start state
  `SCTP_ASSERT_NEXT(a_final_clears, accept && byte_in.final_byte, byte_position == '0 && entries_done == '0 && !error_seen, "parser not cleared after final byte")

endmodule
